/* sv/bdq_pkg.sv */
// Shared types and constants for the bounded double-ended queue.
// Depends on nothing; every other file imports it.
package bdq_pkg;

	localparam int VALUE_W  = 32;
	localparam int ACTION_W = 3;
	localparam int STATUS_W = 2;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH_FRONT = 3'd0,
		ACT_PUSH_BACK  = 3'd1,
		ACT_POP_FRONT  = 3'd2,
		ACT_POP_BACK   = 3'd3,
		ACT_LIST       = 3'd4
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_DONE   = 2'd0,
		STS_FULL   = 2'd1,
		STS_EMPTY  = 2'd2,
		STS_LISTED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP_WAIT,
		S_LIST
	} ctrl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic    push_front;
		logic    push_back;
		logic    pop_front;
		logic    pop_back;
		logic    list_start;
		logic    list_next;
		logic    out_load;
		logic    out_from_mem;
		status_t out_status;
		logic    out_last;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
		logic full;
		logic list_last;
		logic slot_free;
	} dp_sts_t;

endpackage

/* sv/bdq_if.sv */
// Valid/ready channel interfaces for requests and results.
// Depends on bdq_pkg for field widths.
interface bdq_req_if import bdq_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [ACTION_W-1:0]        action;
	logic signed [VALUE_W-1:0]  item_value;

	modport source (output valid, output action, output item_value, input ready);
	modport sink   (input valid, input action, input item_value, output ready);
endinterface

interface bdq_rsp_if import bdq_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [VALUE_W-1:0]  out_value;
	logic [STATUS_W-1:0]        status;
	logic                       last;

	modport source (output valid, output out_value, output status, output last, input ready);
	modport sink   (input valid, input out_value, input status, input last, output ready);
endinterface

/* sv/bdq_ctrl.sv */
// Controller state machine: decodes requests and sequences pops and listing.
// Depends on bdq_pkg; drives the datapath through dp_cmd_t.
module bdq_ctrl import bdq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [ACTION_W-1:0] action,
	input  dp_sts_t             sts,
	output logic                in_ready,
	output dp_cmd_t             cmd
);

	ctrl_state_t state_q, state_nx;
	logic        accept;

	assign in_ready = (state_q == S_IDLE) && sts.slot_free;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (action)
						ACT_POP_FRONT, ACT_POP_BACK: begin
							if (!sts.empty) state_nx = S_POP_WAIT;
						end
						ACT_LIST: begin
							if (!sts.empty) state_nx = S_LIST;
						end
						default: state_nx = S_IDLE;
					endcase
				end
			end
			S_POP_WAIT: begin
				if (sts.slot_free) state_nx = S_IDLE;
			end
			S_LIST: begin
				if (sts.slot_free && sts.list_last) state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.out_status = STS_DONE;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (action)
						ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
							cmd.out_load   = 1'b1;
							cmd.out_last   = 1'b1;
							cmd.out_status = sts.full ? STS_FULL : STS_DONE;
							cmd.push_front = !sts.full && (action == ACT_PUSH_FRONT);
							cmd.push_back  = !sts.full && (action == ACT_PUSH_BACK);
						end
						ACT_POP_FRONT, ACT_POP_BACK: begin
							if (sts.empty) begin
								cmd.out_load   = 1'b1;
								cmd.out_last   = 1'b1;
								cmd.out_status = STS_EMPTY;
							end else begin
								cmd.pop_front = (action == ACT_POP_FRONT);
								cmd.pop_back  = (action == ACT_POP_BACK);
							end
						end
						ACT_LIST: begin
							if (sts.empty) begin
								cmd.out_load   = 1'b1;
								cmd.out_last   = 1'b1;
								cmd.out_status = STS_EMPTY;
							end else begin
								cmd.list_start = 1'b1;
							end
						end
						default: ; // unused codes: dropped
					endcase
				end
			end
			S_POP_WAIT: begin
				if (sts.slot_free) begin
					cmd.out_load     = 1'b1;
					cmd.out_from_mem = 1'b1;
					cmd.out_last     = 1'b1;
					cmd.out_status   = STS_DONE;
				end
			end
			S_LIST: begin
				if (sts.slot_free) begin
					cmd.out_load     = 1'b1;
					cmd.out_from_mem = 1'b1;
					cmd.out_last     = sts.list_last;
					cmd.out_status   = STS_LISTED;
					cmd.list_next    = !sts.list_last;
				end
			end
			default: ;
		endcase
	end

endmodule

/* sv/bdq_dp.sv */
// Datapath: ring store, front pointer, count, list walker and result register.
// Depends on bdq_pkg; commanded by bdq_ctrl.
module bdq_dp import bdq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dp_cmd_t                    cmd,
	input  logic signed [VALUE_W-1:0]  item_value,
	input  logic                       out_ready,
	output dp_sts_t                    sts,
	output logic                       out_valid,
	output logic signed [VALUE_W-1:0]  out_value,
	output logic [STATUS_W-1:0]        out_status,
	output logic                       out_last
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [VALUE_W-1:0] mem_q [DEPTH];
	logic [VALUE_W-1:0] rd_data_q;
	logic [PW-1:0]      front_q;
	logic [CW-1:0]      count_q;
	logic [PW-1:0]      lp_q;
	logic [CW-1:0]      rem_q;
	logic               out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	logic [STATUS_W-1:0] out_status_q;
	logic               out_last_q;

	logic               wr_en, rd_en;
	logic [PW-1:0]      wr_addr, rd_addr;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
		return (p == '0) ? PW'(DEPTH - 1) : p - 1'b1;
	endfunction

	function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] a, input logic [PW-1:0] b);
		logic [PW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (PW+1)'(DEPTH)) s = s - (PW+1)'(DEPTH);
		return s[PW-1:0];
	endfunction

	assign sts.empty     = (count_q == '0);
	assign sts.full      = (count_q == CW'(DEPTH));
	assign sts.list_last = (rem_q == '0);
	assign sts.slot_free = !out_valid_q || out_ready;

	assign wr_en   = cmd.push_front || cmd.push_back;
	assign wr_addr = cmd.push_front ? ptr_dec(front_q) : ptr_add(front_q, count_q[PW-1:0]);

	assign rd_en = cmd.pop_front || cmd.pop_back || cmd.list_start || cmd.list_next;

	always_comb begin
		rd_addr = front_q;
		if (cmd.pop_back)  rd_addr = ptr_add(front_q, PW'(count_q - 1'b1));
		if (cmd.list_next) rd_addr = ptr_inc(lp_q);
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= item_value;
		if (rd_en) rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else begin
			if (cmd.push_front) begin
				front_q <= ptr_dec(front_q);
				count_q <= count_q + 1'b1;
			end
			if (cmd.push_back) count_q <= count_q + 1'b1;
			if (cmd.pop_front) begin
				front_q <= ptr_inc(front_q);
				count_q <= count_q - 1'b1;
			end
			if (cmd.pop_back) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.list_start) begin
			lp_q  <= rd_addr;
			rem_q <= count_q - 1'b1;
		end else if (cmd.list_next) begin
			lp_q  <= rd_addr;
			rem_q <= rem_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_value_q  <= cmd.out_from_mem ? rd_data_q : '0;
			out_status_q <= cmd.out_status;
			out_last_q   <= cmd.out_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_value  = out_value_q;
	assign out_status = out_status_q;
	assign out_last   = out_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_front || cmd.push_back) |-> !sts.full)
		else $error("push issued on full store");

	a_no_read_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pop_front || cmd.pop_back || cmd.list_start) |-> !sts.empty)
		else $error("read issued on empty store");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.slot_free)
		else $error("result register overwritten");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_front || cmd.push_back) |=> count_q == $past(count_q) + 1'b1)
		else $error("push did not grow count");

endmodule

/* sv/bounded_double_ended_queue.sv */
// Top level of the bounded double-ended queue: controller plus datapath.
// Depends on bdq_pkg, bdq_req_if/bdq_rsp_if, bdq_ctrl and bdq_dp.
//
//   channel  dir  handshake    payload
//   req      in   valid/ready  action, item_value
//   rsp      out  valid/ready  out_value, status, last
//
// Push, and any request on a full/empty store: result registered in the cycle after accept.
// Pop: registered read of the ring store, then loaded into the result register once it is free.
// List of N entries: first entry read and loaded the same way, then one per cycle while rsp is not stalled.
// Next request accepted once the sequence is done and the result register is free.
// arst_n clears pointer, count and the state machine; the store needs no clearing.
// rsp stalls hold the result register; the list walk pauses with it.
module bounded_double_ended_queue import bdq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	bdq_req_if.sink    req,
	bdq_rsp_if.source  rsp
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	bdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.action   (req.action),
		.sts      (sts),
		.in_ready (req.ready),
		.cmd      (cmd)
	);

	bdq_dp #(.DEPTH(DEPTH)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.item_value (req.item_value),
		.out_ready  (rsp.ready),
		.sts        (sts),
		.out_valid  (rsp.valid),
		.out_value  (rsp.out_value),
		.out_status (rsp.status),
		.out_last   (rsp.last)
	);

endmodule

/* verif/bdq_checker.sv */
`timescale 1ns / 100ps
// Checker for the bounded double-ended queue: tracks the ring contents from accepted
// requests and compares every accepted result, field by field, in order.
// Depends on bdq_pkg and the bdq_req_if / bdq_rsp_if interfaces.
module bdq_checker import bdq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	bdq_req_if   req,
	bdq_rsp_if   rsp,
	output int   fail_count,
	output int   pending,
	output int   results_seen,
	output int   full_drops,
	output int   empty_hits
);

	typedef struct {
		logic signed [VALUE_W-1:0] value;
		status_t                   status;
		logic                      last;
	} deque_result_t;

	deque_result_t             due_results[$];
	deque_result_t             due_head;
	logic signed [VALUE_W-1:0] shadow_ring [DEPTH];
	int unsigned               front_pos;
	int unsigned               held;

	function automatic void queue_result(input logic signed [VALUE_W-1:0] value,
			input status_t status, input logic last);
		deque_result_t r;
		r.value  = value;
		r.status = status;
		r.last   = last;
		due_results.push_back(r);
	endfunction

	// apply one request to the shadow ring and queue the results it owes
	task automatic deque_step(input logic [ACTION_W-1:0] act,
			input logic signed [VALUE_W-1:0] val);
		int unsigned pos;
		case (act)
			ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
				if (held == DEPTH) begin
					queue_result('0, STS_FULL, 1'b1);
				end else begin
					if (act == ACT_PUSH_FRONT) begin
						front_pos = (front_pos + DEPTH - 1) % DEPTH;
						pos = front_pos;
					end else begin
						pos = (front_pos + held) % DEPTH;
					end
					shadow_ring[pos] = val;
					held++;
					queue_result('0, STS_DONE, 1'b1);
				end
			end
			ACT_POP_FRONT: begin
				if (held == 0) begin
					queue_result('0, STS_EMPTY, 1'b1);
				end else begin
					queue_result(shadow_ring[front_pos], STS_DONE, 1'b1);
					front_pos = (front_pos + 1) % DEPTH;
					held--;
				end
			end
			ACT_POP_BACK: begin
				if (held == 0) begin
					queue_result('0, STS_EMPTY, 1'b1);
				end else begin
					queue_result(shadow_ring[(front_pos + held - 1) % DEPTH], STS_DONE, 1'b1);
					held--;
				end
			end
			ACT_LIST: begin
				if (held == 0) begin
					queue_result('0, STS_EMPTY, 1'b1);
				end else begin
					for (int unsigned i = 0; i < held; i++) begin
						queue_result(shadow_ring[(front_pos + i) % DEPTH], STS_LISTED,
							i + 1 == held);
					end
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_results.delete();
			front_pos    = 0;
			held         = 0;
			fail_count   = 0;
			results_seen = 0;
			full_drops   = 0;
			empty_hits   = 0;
			pending     <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				results_seen++;
				if (rsp.status == STS_FULL) full_drops++;
				if (rsp.status == STS_EMPTY) empty_hits++;
				if (due_results.size() == 0) begin
					$error("unexpected result: out_value %0d status %0d last %0b",
						rsp.out_value, rsp.status, rsp.last);
					fail_count++;
				end else begin
					due_head = due_results.pop_front();
					if (rsp.out_value !== due_head.value) begin
						$error("out_value: expected %0d, got %0d", due_head.value, rsp.out_value);
						fail_count++;
					end
					if (rsp.status !== due_head.status) begin
						$error("status: expected %0d, got %0d", due_head.status, rsp.status);
						fail_count++;
					end
					if (rsp.last !== due_head.last) begin
						$error("last: expected %0b, got %0b", due_head.last, rsp.last);
						fail_count++;
					end
				end
			end
			if (req.valid && req.ready)
				deque_step(req.action, req.item_value);
			pending <= due_results.size();
		end
	end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// Top of the bounded double-ended queue testbench: clock, reset, request and
// result-side stimulus with random idling, and the verdict. Depends on bdq_pkg,
// the bdq interfaces, bounded_double_ended_queue and bdq_checker.
module tb_top import bdq_pkg::*; ();

	localparam int DEPTH        = 16;
	localparam int RANDOM_COUNT = 180;
	localparam int CALM_TAIL    = 30;
	localparam int LONG_STALL   = 60;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   results_seen;
	int   full_drops;
	int   empty_hits;
	int   requests_sent;
	int   ignored_sent;
	bit   steady;
	bit   stall_long;

	bdq_req_if req ();
	bdq_rsp_if rsp ();

	bounded_double_ended_queue #(.DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	bdq_checker #(.DEPTH(DEPTH)) bdq_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.rsp          (rsp),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen),
		.full_drops   (full_drops),
		.empty_hits   (empty_hits)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [ACTION_W-1:0] pick_action();
		logic [ACTION_W-1:0] act;
		case ($urandom_range(0, 19))
			0, 1, 2, 3:     act = ACT_PUSH_FRONT;
			4, 5, 6, 7, 18: act = ACT_PUSH_BACK;
			8, 9, 10:       act = ACT_POP_FRONT;
			11, 12, 13:     act = ACT_POP_BACK;
			14, 15, 16:     act = ACT_LIST;
			17:             act = ACTION_W'($urandom_range(5, 7));
			default:        act = ACT_PUSH_BACK;
		endcase
		return act;
	endfunction

	task automatic send_request(input logic [ACTION_W-1:0] act,
			input logic signed [VALUE_W-1:0] val);
		if (!steady && $urandom_range(0, 4) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		req.valid      <= 1'b1;
		req.action     <= act;
		req.item_value <= val;
		do @(posedge clk); while (!req.ready);
		if (act <= ACT_LIST)
			requests_sent++;
		else
			ignored_sent++;
	endtask

	// hold off new requests until every owed result is back
	task automatic drain_wait();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// result side: random stall bursts, one long hold-off on request, none in the tail
	initial begin
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (stall_long) begin
				rsp.ready <= 1'b0;
				repeat (LONG_STALL) @(posedge clk);
				stall_long = 1'b0;
			end else if (!steady && $urandom_range(0, 4) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				rsp.ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	initial begin
		int seq;
		int mode;
		int target;
		requests_sent = 0;
		ignored_sent  = 0;
		steady        = 1'b0;
		stall_long    = 1'b0;
		arst_n         <= 1'b0;
		req.valid      <= 1'b0;
		req.action     <= ACT_PUSH_FRONT;
		req.item_value <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store, extremes, both ends, unused codes
		send_request(ACT_LIST, pick_value());
		send_request(ACT_POP_FRONT, pick_value());
		send_request(ACT_POP_BACK, pick_value());
		send_request(ACT_PUSH_FRONT, 32'h7fff_ffff);
		send_request(ACT_PUSH_BACK, 32'h8000_0000);
		send_request(ACT_PUSH_FRONT, '0);
		send_request(ACT_PUSH_BACK, '1);
		send_request(ACT_LIST, pick_value());
		send_request(3'd5, pick_value());
		send_request(3'd6, pick_value());
		send_request(3'd7, pick_value());
		send_request(ACT_POP_BACK, pick_value());
		send_request(ACT_POP_FRONT, pick_value());
		send_request(ACT_LIST, pick_value());
		send_request(ACT_POP_FRONT, pick_value());
		send_request(ACT_POP_BACK, pick_value());
		send_request(ACT_POP_FRONT, pick_value());
		send_request(ACT_LIST, pick_value());
		drain_wait();

		target = requests_sent + RANDOM_COUNT;
		seq = 0;
		while (requests_sent < target) begin
			steady = (requests_sent >= target - CALM_TAIL);
			mode = $urandom_range(0, 9);
			if (seq == 3)
				stall_long = 1'b1;
			if (seq == 3 || mode < 3) begin
				// fill past full, then list
				repeat (DEPTH + $urandom_range(1, 3))
					send_request($urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK,
						pick_value());
				send_request(ACT_LIST, pick_value());
			end else if (mode < 5) begin
				// drain past empty, then list
				repeat (DEPTH + $urandom_range(1, 2))
					send_request($urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK,
						pick_value());
				send_request(ACT_LIST, pick_value());
			end else begin
				repeat ($urandom_range(4, 16))
					send_request(pick_action(), pick_value());
			end
			if (seq == 5 || (!steady && $urandom_range(0, 5) == 0))
				drain_wait();
			seq++;
		end

		drain_wait();
		repeat (8) @(posedge clk);
		$display("Run covered %0d requests and %0d unused action codes.",
			requests_sent, ignored_sent);
		$display("Checked %0d results: %0d full drops, %0d empty-store results.",
			results_seen, full_drops, empty_hits);
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
